[hdl/rcrd_pkg.sv]
`timescale 1ns / 1ps
// Package of the ring corner response detector: item types, register codes and ring tables.
package rcrd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_RADIUS = 10;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIUS_SELECT,
    CFG_CORNER_THRESHOLD,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT
  } cfg_index_e;

  localparam logic               RST_RADIUS_SELECT    = 1'b0;
  localparam logic signed [11:0] RST_CORNER_THRESHOLD = 12'sd100;
  localparam logic [11:0]        RST_FRAME_WIDTH      = 12'd640;
  localparam logic [11:0]        RST_FRAME_HEIGHT     = 12'd480;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [10:0]        center_col;
    logic [10:0]        center_row;
    logic signed [11:0] response;
    logic               is_corner;
    logic               frame_last;
  } corner_res_t;

  // Ring sample offsets, indexed by quadrant group and then by sample within the group.
  localparam int RING5_DY [4][4] = '{
    '{0, -2, -4, -5}, '{-5, -5, -4, -2}, '{0, 2, 4, 5}, '{5, 5, 4, 2}};
  localparam int RING5_DX [4][4] = '{
    '{-5, -5, -4, -2}, '{0, 2, 4, 5}, '{5, 5, 4, 2}, '{0, -2, -4, -5}};
  localparam int RING10_DY [4][4] = '{
    '{0, -4, -7, -10}, '{-10, -10, -7, -4}, '{0, 4, 7, 10}, '{10, 10, 7, 4}};
  localparam int RING10_DX [4][4] = '{
    '{-10, -10, -7, -4}, '{0, 4, 7, 10}, '{10, 10, 7, 4}, '{0, -4, -7, -10}};

endpackage

[hdl/ring_corner_response_detector_unit.sv]
`timescale 1ns / 1ps
// Ring corner response detector: line store, sample window and corner response pipeline.
//
// Channel  | Direction | Handshake               | Item
// ---------+-----------+-------------------------+------------------------------------------
// in       | input     | in_valid_i / in_ready_o | pixel, frame_start
// out      | output    | out_valid_o/out_ready_i | center_col, center_row, response, flags
// cfg      | input     | cfg_valid_i/cfg_ready_o | register index, 12-bit write data
//
// One pixel item is taken per clock while in_ready_o is high; an item passes the stage 1, 2
// and 3 registers, and its result then enters the output register. The rate is set by the
// line store, which has one read port and one write port and is read and written once per item
// (a column of all stored rows). Reset clears the counters, the configuration registers and
// all valid flags; the line store is not cleared. A stalled output holds one result in its
// register and one in a skid entry; in_ready_o falls only while the skid entry is occupied.
module ring_corner_response_detector_unit #(
  parameter int MaxWidth  = rcrd_pkg::MAX_WIDTH,
  parameter int MaxHeight = rcrd_pkg::MAX_HEIGHT,
  parameter int MaxRadius = rcrd_pkg::MAX_RADIUS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  rcrd_pkg::pix_in_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output rcrd_pkg::corner_res_t                out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rcrd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [rcrd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int Rows   = 2 * MaxRadius + 1;
  localparam int MinDim = 2 * MaxRadius + 3;
  localparam int SW     = $clog2(Rows);
  localparam int CW     = $clog2(MaxWidth);
  localparam int RW     = $clog2(MaxHeight);

  typedef struct packed {
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          emit;
    logic          border;
    logic          last;
    logic          rad10;
  } meta_t;

  function automatic logic signed [10:0] abs11(input logic signed [10:0] v);
    return v[10] ? -v : v;
  endfunction

  // Configuration registers.
  logic               cfg_rad_q;
  logic signed [11:0] cfg_thr_q;
  logic [11:0]        cfg_width_q;
  logic [11:0]        cfg_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rad_q    <= rcrd_pkg::RST_RADIUS_SELECT;
      cfg_thr_q    <= rcrd_pkg::RST_CORNER_THRESHOLD;
      cfg_width_q  <= rcrd_pkg::RST_FRAME_WIDTH;
      cfg_height_q <= rcrd_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rcrd_pkg::CFG_RADIUS_SELECT:    cfg_rad_q    <= cfg_data_i[0];
        rcrd_pkg::CFG_CORNER_THRESHOLD: cfg_thr_q    <= $signed(cfg_data_i);
        rcrd_pkg::CFG_FRAME_WIDTH:      cfg_width_q  <= cfg_data_i;
        rcrd_pkg::CFG_FRAME_HEIGHT:     cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame limits, clamped to the supported range.
  logic [31:0] fw32, fh32, wv32, hv32;
  logic [CW:0] w_lim;
  logic [RW:0] h_lim;

  always_comb begin
    fw32 = 32'(cfg_width_q);
    fh32 = 32'(cfg_height_q);
    if (fw32 < MinDim) begin
      wv32 = 32'(MinDim);
    end else if (fw32 > MaxWidth) begin
      wv32 = 32'(MaxWidth);
    end else begin
      wv32 = fw32;
    end
    if (fh32 < MinDim) begin
      hv32 = 32'(MinDim);
    end else if (fh32 > MaxHeight) begin
      hv32 = 32'(MaxHeight);
    end else begin
      hv32 = fh32;
    end
    w_lim = wv32[CW:0];
    h_lim = hv32[RW:0];
  end

  // Pipeline control.
  logic adv, accept;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;

  assign adv        = !skid_valid_q;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Position counters and row slot of the line store.
  logic [CW-1:0] col_q, col_d, c0, cur_col;
  logic [RW-1:0] row_q, row_d, r0, cur_row;
  logic [SW-1:0] slot_q, slot_d, sl0, cur_slot;
  logic [RW:0]   r1, nr;
  logic [CW:0]   nc;
  logic          rad10_s0;
  logic [4:0]    twice_rad;
  meta_t         meta_s0;

  always_comb begin
    c0       = in_item_i.frame_start ? '0 : col_q;
    r0       = in_item_i.frame_start ? '0 : row_q;
    sl0      = in_item_i.frame_start ? '0 : slot_q;
    r1       = {1'b0, r0};
    cur_col  = c0;
    cur_slot = sl0;
    if ({1'b0, c0} >= w_lim) begin
      cur_col  = '0;
      r1       = {1'b0, r0} + 1'b1;
      cur_slot = (sl0 == SW'(Rows - 1)) ? '0 : sl0 + 1'b1;
    end
    if (r1 >= h_lim) begin
      r1       = '0;
      cur_slot = '0;
    end
    cur_row = r1[RW-1:0];

    nc     = {1'b0, cur_col} + 1'b1;
    nr     = {1'b0, cur_row} + 1'b1;
    col_d  = nc[CW-1:0];
    row_d  = cur_row;
    slot_d = cur_slot;
    if (nc >= w_lim) begin
      col_d = '0;
      if (nr >= h_lim) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = nr[RW-1:0];
        slot_d = (cur_slot == SW'(Rows - 1)) ? '0 : cur_slot + 1'b1;
      end
    end
  end

  always_comb begin
    rad10_s0       = cfg_rad_q && (MaxRadius >= 10);
    twice_rad      = rad10_s0 ? 5'd20 : 5'd10;
    meta_s0.col    = cur_col;
    meta_s0.row    = cur_row;
    meta_s0.emit   = (32'(cur_row) >= 32'(twice_rad)) && (32'(cur_col) >= 32'(twice_rad));
    meta_s0.border = (32'(cur_col) == 32'(twice_rad)) || (32'(cur_row) == 32'(twice_rad))
                     || ({1'b0, cur_col} == w_lim - 1'b1)
                     || ({1'b0, cur_row} == h_lim - 1'b1);
    meta_s0.last   = ({1'b0, cur_col} == w_lim - 1'b1) && ({1'b0, cur_row} == h_lim - 1'b1);
    meta_s0.rad10  = rad10_s0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Stage 1: column read, pixel merge and write-back.
  logic                s1_valid_q;
  meta_t               s1_q;
  logic [SW-1:0]       s1_slot_q;
  logic [7:0]          s1_pix_q;
  logic                s1_fwd_q;
  logic [Rows*8-1:0]   mem [MaxWidth];
  logic [Rows*8-1:0]   rdata_q, fwd_word_q, base_word, wr_word;
  logic [7:0]          mrg [Rows];
  logic [7:0]          colvec [Rows];
  logic [SW-1:0]       rot_idx [Rows];
  logic                wr_en;

  assign wr_en = adv && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[cur_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_q.col] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= meta_s0;
      s1_slot_q <= cur_slot;
      s1_pix_q  <= in_item_i.pixel;
      s1_fwd_q  <= s1_valid_q && (s1_q.col == cur_col);
    end
    if (wr_en) begin
      fwd_word_q <= wr_word;
    end
  end

  always_comb begin
    base_word = s1_fwd_q ? fwd_word_q : rdata_q;
    for (int s = 0; s < Rows; s++) begin
      mrg[s]            = (s1_slot_q == SW'(s)) ? s1_pix_q : base_word[s*8 +: 8];
      wr_word[s*8 +: 8] = mrg[s];
    end
    for (int k = 0; k < Rows; k++) begin
      if (s1_slot_q >= SW'(k)) begin
        rot_idx[k] = s1_slot_q - SW'(k);
      end else begin
        rot_idx[k] = SW'(int'(s1_slot_q) + Rows - k);
      end
      colvec[k] = mrg[rot_idx[k]];
    end
  end

  // Stage 2: sample window, row index by age of the row, column index by age of the column.
  logic [7:0] win_q [Rows][Rows];
  logic       s2_valid_q;
  meta_t      s2_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int k = 0; k < Rows; k++) begin
        for (int j = 0; j < Rows; j++) begin
          if (j == 0) begin
            win_q[k][j] <= colvec[k];
          end else begin
            win_q[k][j] <= win_q[k][j-1];
          end
        end
      end
    end
    if (adv) begin
      s2_q <= s1_q;
    end
  end

  logic [7:0] smp [4][4];

  for (genvar g = 0; g < 4; g++) begin : g_grp
    for (genvar i = 0; i < 4; i++) begin : g_smp
      if (MaxRadius >= 10) begin : g_both
        assign smp[g][i] = s2_q.rad10
          ? win_q[10 - rcrd_pkg::RING10_DY[g][i]][10 - rcrd_pkg::RING10_DX[g][i]]
          : win_q[5 - rcrd_pkg::RING5_DY[g][i]][5 - rcrd_pkg::RING5_DX[g][i]];
      end else begin : g_r5
        assign smp[g][i] = win_q[5 - rcrd_pkg::RING5_DY[g][i]][5 - rcrd_pkg::RING5_DX[g][i]];
      end
    end
  end

  logic signed [10:0] sac [4], sbd [4], dsr [4], dac [4], dbd [4], drv [4];
  logic signed [9:0]  term [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sac[i]  = $signed({3'b000, smp[0][i]}) + $signed({3'b000, smp[2][i]});
      sbd[i]  = $signed({3'b000, smp[1][i]}) + $signed({3'b000, smp[3][i]});
      dsr[i]  = sac[i] - sbd[i];
      dac[i]  = $signed({3'b000, smp[0][i]}) - $signed({3'b000, smp[2][i]});
      dbd[i]  = $signed({3'b000, smp[1][i]}) - $signed({3'b000, smp[3][i]});
      drv[i]  = abs11(dac[i]) + abs11(dbd[i]);
      term[i] = 10'(abs11(dsr[i]) - drv[i]);
    end
  end

  // Stage 3: sum of the group terms, border case and threshold.
  logic               s3_valid_q;
  meta_t              s3_q;
  logic signed [9:0]  term_q [4];
  logic signed [11:0] sum_s3, resp_s3;
  logic [CW-1:0]      cx_s3;
  logic [RW-1:0]      cy_s3;
  logic [31:0]        cx32, cy32;
  logic               res_valid;
  rcrd_pkg::corner_res_t res_s3;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q <= s2_q;
      for (int i = 0; i < 4; i++) begin
        term_q[i] <= term[i];
      end
    end
  end

  always_comb begin
    sum_s3  = {{2{term_q[0][9]}}, term_q[0]} + {{2{term_q[1][9]}}, term_q[1]}
            + {{2{term_q[2][9]}}, term_q[2]} + {{2{term_q[3][9]}}, term_q[3]};
    resp_s3 = s3_q.border ? '0 : sum_s3;
    cx_s3   = s3_q.col - (s3_q.rad10 ? CW'(10) : CW'(5));
    cy_s3   = s3_q.row - (s3_q.rad10 ? RW'(10) : RW'(5));
    cx32    = 32'(cx_s3);
    cy32    = 32'(cy_s3);
    res_s3.center_col = cx32[10:0];
    res_s3.center_row = cy32[10:0];
    res_s3.response   = resp_s3;
    res_s3.is_corner  = resp_s3 > cfg_thr_q;
    res_s3.frame_last = s3_q.last;
    res_valid         = s3_valid_q && s3_q.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Output register with one skid entry.
  rcrd_pkg::corner_res_t out_q, out_d, skid_q, skid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_d       = res_s3;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_s3;
        skid_valid_d = 1'b1;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The skid entry is only ever filled behind a held output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while the output register is empty");

  // The last centre of a frame always lies on the outer scanned ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_last) |-> (out_item_o.response == 12'sd0))
    else $error("last result of a frame carries a non-zero response");

  // Forwarded column data must come from an item at the same column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> (s1_q.col == $past(s1_q.col)))
    else $error("line store forwarding used across different columns");

endmodule
